FILE: sv/jeg_pkg.sv
// ----------------------------------------------------------------------------
// jeg_pkg: shared types and constants of the Japanese encoding guesser
// Byte classes, ISO-2022-JP escape matching and the verdict codes.
// ----------------------------------------------------------------------------
`default_nettype none

package jeg_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned PosW     = 17;
  localparam int unsigned PenW     = 20;
  localparam int unsigned AddW     = 4;
  localparam int unsigned SpanLen  = 6;
  localparam int unsigned WinDepth = SpanLen - 1;

  localparam logic [LimitW-1:0] LimitReset = 16'hffff;
  localparam logic [PosW-1:0]   PosMax     = 17'h1ffff;
  localparam logic [PenW-1:0]   PenMax     = 20'hfffff;

  localparam logic [AddW-1:0] AddNone  = 4'd0;
  localparam logic [AddW-1:0] AddSmall = 4'd1;
  localparam logic [AddW-1:0] AddLarge = 4'd10;

  // Byte values used by the scoring rules
  localparam logic [7:0] ChEsc      = 8'h1b;
  localparam logic [7:0] ChDollar   = 8'h24;
  localparam logic [7:0] ChAmp      = 8'h26;
  localparam logic [7:0] ChParen    = 8'h28;
  localparam logic [7:0] ChAt       = 8'h40;
  localparam logic [7:0] ChB        = 8'h42;
  localparam logic [7:0] ChD        = 8'h44;
  localparam logic [7:0] ChI        = 8'h49;
  localparam logic [7:0] ChJ        = 8'h4a;
  localparam logic [7:0] EucKana    = 8'h8e;
  localparam logic [7:0] EucLevel2  = 8'hd0;
  localparam logic [15:0] SjisLevel2 = 16'h989f;

  typedef enum logic [2:0] {
    VerdictIso2022 = 3'd0,
    VerdictSjis    = 3'd1,
    VerdictEuc     = 3'd2,
    VerdictAscii   = 3'd3,
    VerdictUnknown = 3'd4
  } verdict_e;

  // Six bytes, index 0 is the oldest
  typedef logic [SpanLen-1:0][7:0] span_t;

  function automatic logic in_euc(input logic [7:0] c);
    return (c >= 8'ha1) && (c <= 8'hfe);
  endfunction

  function automatic logic in_kana(input logic [7:0] c);
    return (c >= 8'ha0) && (c <= 8'hdf);
  endfunction

  function automatic logic in_sj1(input logic [7:0] c);
    return ((c >= 8'h81) && (c <= 8'h9f)) || ((c >= 8'he0) && (c <= 8'hef));
  endfunction

  function automatic logic in_sj2(input logic [7:0] c);
    return (c >= 8'h40) && (c <= 8'hfc) && (c != 8'h7f);
  endfunction

  // True when the span opens with one of the seven ISO-2022-JP escapes
  function automatic logic esc_match(input span_t s);
    logic hit;
    hit = 1'b0;
    if (s[0] == ChEsc) begin
      if (s[1] == ChDollar && (s[2] == ChAt || s[2] == ChB)) hit = 1'b1;
      if (s[1] == ChAmp && s[2] == ChAt && s[3] == ChEsc && s[4] == ChDollar &&
          s[5] == ChB) hit = 1'b1;
      if (s[1] == ChDollar && s[2] == ChParen && s[3] == ChD) hit = 1'b1;
      if (s[1] == ChParen && (s[2] == ChB || s[2] == ChJ || s[2] == ChI)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

FILE: sv/japanese_encoding_guesser_core.sv
// ----------------------------------------------------------------------------
// japanese_encoding_guesser_core: ISO-2022-JP / SJIS / EUC-JP guesser
// Scores a byte string and reports one encoding verdict per string.
// ----------------------------------------------------------------------------
// Usage:
//   Feed a string on the slave stream one byte per transfer, tdata[7:0] the
//   byte and tlast on its final byte. Each string yields exactly one verdict
//   transfer on the master stream (tdata[2:0]); other bytes yield nothing.
//   scan_limit is written through cfg_wr_en_i / cfg_wr_data_i while idle.
//   Output: the last byte sits in the input register, and the scoring logic
//   loads the verdict into the result register from there.
//   Throughput: one byte per cycle while no last byte is held back (see
//   Stall); the per-byte state update (window shift, escape match and one
//   saturating score add per encoding) is combinational from the input
//   register.
//   Stall: while a verdict waits for m_axis_tready, bytes of the next string
//   keep flowing until its last byte, which holds in the input register.
//   Reset clears the per-string counters, flags and scores (not the byte window) and sets scan_limit to 65535.
// ----------------------------------------------------------------------------
`default_nettype none

module japanese_encoding_guesser_core #(
  parameter int unsigned LimitW = jeg_pkg::LimitW
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  // Configuration: scan_limit
  input  wire                cfg_wr_en_i,
  input  wire  [LimitW-1:0]  cfg_wr_data_i,
  // Slave stream
  input  wire                s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire  [7:0]         s_axis_tdata,   // [7:0] text_byte
  input  wire                s_axis_tlast,   // is_last
  // Master stream
  output logic               m_axis_tvalid,
  input  wire                m_axis_tready,
  output logic [7:0]         m_axis_tdata    // [2:0] verdict, [7:3] zero
);
  import jeg_pkg::*;

  localparam int unsigned PosW2 = (LimitW + 1 > PosW) ? LimitW + 1 : PosW;

  // Input register
  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             in_last_q;

  // Per-string state
  logic [7:0]       win_q [WinDepth];
  logic [PosW-1:0]  pos_q;
  logic             esc_q;
  logic             euc_pend_q, sjis_pend_q;
  logic [PenW-1:0]  euc_pen_q, sjis_pen_q;
  logic [LimitW-1:0] limit_q;

  // Result register
  logic             out_valid_q;
  verdict_e         verdict_q;

  logic             fire;
  logic             out_free;

  // Fire the scoring stage unless a verdict would overwrite one still waiting
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || fire;

  // Capture the incoming transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset[LimitW-1:0];
    end else if (cfg_wr_en_i) begin
      limit_q <= cfg_wr_data_i;
    end
  end

  // Scoring logic
  span_t           span;
  logic [7:0]      lead, trail;
  logic [PosW2-1:0] pos_x, lim_x;
  logic            esc_ok, score_ok, pair_ok;
  logic            esc_d;
  logic            euc_pend_d, sjis_pend_d;
  logic [AddW-1:0] euc_add, sjis_add;
  logic [PenW:0]   euc_sum, sjis_sum;
  logic [PenW-1:0] euc_pen_d, sjis_pen_d;
  logic [PosW-1:0] pos_d;
  verdict_e        verdict_d;

  always_comb begin
    for (int k = 0; k < WinDepth; k++) begin
      span[k] = win_q[WinDepth-1-k];
    end
    span[SpanLen-1] = in_byte_q;
    lead  = win_q[1];
    trail = win_q[0];

    pos_x = PosW2'(pos_q);
    lim_x = PosW2'(limit_q);
    // escape starting at pos-5 lies below the limit
    esc_ok   = (pos_q >= PosW'(5)) && ((pos_x - PosW2'(5)) < lim_x);
    // scoring position pos-2, and its trail at pos-1, below the limit
    score_ok = (pos_q >= PosW'(2)) && ((pos_x - PosW2'(2)) < lim_x);
    pair_ok  = (pos_x - PosW2'(1)) < lim_x;

    esc_d = esc_q || (esc_ok && esc_match(span));

    // EUC-JP
    euc_add    = AddNone;
    euc_pend_d = 1'b0;
    if (pos_q >= PosW'(2) && !euc_pend_q && score_ok) begin
      if (in_euc(lead) || lead == EucKana) begin
        if (pair_ok) begin
          if (lead == EucKana ? in_kana(trail) : in_euc(trail)) begin
            euc_add    = (lead == EucKana || lead >= EucLevel2) ? AddSmall : AddNone;
            euc_pend_d = 1'b1;
          end else begin
            euc_add = AddLarge;
          end
        end
      end else if (lead[7]) begin
        euc_add = AddLarge;
      end
    end

    // SJIS
    sjis_add    = AddNone;
    sjis_pend_d = 1'b0;
    if (pos_q >= PosW'(2) && !sjis_pend_q && score_ok) begin
      if (in_sj1(lead)) begin
        if (pair_ok) begin
          if (in_sj2(trail)) begin
            sjis_add    = ({lead, trail} >= SjisLevel2) ? AddSmall : AddNone;
            sjis_pend_d = 1'b1;
          end else begin
            sjis_add = AddLarge;
          end
        end
      end else if (lead[7]) begin
        sjis_add = in_kana(lead) ? AddSmall : AddLarge;
      end
    end

    // Saturating score update
    euc_sum    = {1'b0, euc_pen_q} + (PenW + 1)'(euc_add);
    sjis_sum   = {1'b0, sjis_pen_q} + (PenW + 1)'(sjis_add);
    euc_pen_d  = (euc_sum > {1'b0, PenMax}) ? PenMax : euc_sum[PenW-1:0];
    sjis_pen_d = (sjis_sum > {1'b0, PenMax}) ? PenMax : sjis_sum[PenW-1:0];

    pos_d = (pos_q < PosMax) ? pos_q + PosW'(1) : pos_q;

    // Verdict from the updated state
    if (esc_d) begin
      verdict_d = VerdictIso2022;
    end else if (sjis_pen_d < euc_pen_d) begin
      verdict_d = VerdictSjis;
    end else if (sjis_pen_d > euc_pen_d) begin
      verdict_d = VerdictEuc;
    end else if (sjis_pen_d == '0) begin
      verdict_d = VerdictAscii;
    end else begin
      verdict_d = VerdictUnknown;
    end
  end

  // Advance the byte window
  always_ff @(posedge clk_i) begin
    if (fire) begin
      win_q[0] <= in_byte_q;
      for (int k = 1; k < WinDepth; k++) begin
        win_q[k] <= win_q[k-1];
      end
    end
  end

  // Update per-string state; clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      esc_q       <= 1'b0;
      euc_pend_q  <= 1'b0;
      sjis_pend_q <= 1'b0;
      euc_pen_q   <= '0;
      sjis_pen_q  <= '0;
    end else if (fire) begin
      if (in_last_q) begin
        pos_q       <= '0;
        esc_q       <= 1'b0;
        euc_pend_q  <= 1'b0;
        sjis_pend_q <= 1'b0;
        euc_pen_q   <= '0;
        sjis_pen_q  <= '0;
      end else begin
        pos_q       <= pos_d;
        esc_q       <= esc_d;
        euc_pend_q  <= euc_pend_d;
        sjis_pend_q <= sjis_pend_d;
        euc_pen_q   <= euc_pen_d;
        sjis_pen_q  <= sjis_pen_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_last_q) begin
      verdict_q <= verdict_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, verdict_q};

endmodule

`default_nettype wire

FILE: tb/sv/tb_japanese_encoding_guesser_core.sv
// ----------------------------------------------------------------------------
// tb_japanese_encoding_guesser_core: self-checking bench of the encoding guesser
// Streams byte strings into the core and checks unpinned verdicts against an
// in-bench scorer that tracks escapes, both penalty scores and the scan limit.
// A short table of probe strings comes first, then random strings under three
// idling regimes and several scan limits, and a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_japanese_encoding_guesser_core;

  import jeg_pkg::*;

  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned BytesPerSet  = 55;
  localparam int unsigned NumProbes    = 9;

  // One ISO-2022-JP escape: length and bytes, first byte in seq[0]
  typedef struct packed {
    logic [2:0]      len;
    logic [0:5][7:0] seq;
  } esc_t;

  // One probe string; want is used only where pinned is set
  typedef struct packed {
    logic [15:0]     limit;
    logic [3:0]      len;
    logic [0:5][7:0] txt;
    logic            pinned;
    verdict_e        want;
  } probe_row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_wr_en_i   = 1'b0;
  logic [LimitW-1:0] cfg_wr_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;
  logic              s_axis_tlast  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;

  // Scorer state
  logic [7:0]        win [SpanLen];
  logic [PosW-1:0]   byte_pos   = '0;
  logic              esc_hit    = 1'b0;
  logic [8:0]        euc_pend   = '0;
  logic [8:0]        sjis_pend  = '0;
  logic [PenW-1:0]   euc_pen    = '0;
  logic [PenW-1:0]   sjis_pen   = '0;
  logic [LimitW-1:0] scan_lim   = LimitReset;

  verdict_e          verdict_q [$];
  logic [7:0]        text_q [$];
  logic              pin_on     = 1'b0;
  verdict_e          pin_want   = VerdictAscii;
  int unsigned       fail_cnt   = 0;
  int unsigned       stall_cnt  = 0;
  int unsigned       send_idle  = 0;
  int unsigned       recv_idle  = 0;
  int unsigned       hold_left  = 0;
  logic              hold_start = 1'b0;
  probe_row_t        probe_tab [NumProbes];

  japanese_encoding_guesser_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    for (int k = 0; k < SpanLen; k++) win[k] = 8'h00;
  end

  // Byte classes
  function automatic logic euc_range(input logic [7:0] c);
    return (c >= 8'ha1) && (c <= 8'hfe);
  endfunction

  function automatic logic kana_range(input logic [7:0] c);
    return (c >= 8'ha0) && (c <= 8'hdf);
  endfunction

  function automatic logic sj_lead_range(input logic [7:0] c);
    return ((c >= 8'h81) && (c <= 8'h9f)) || ((c >= 8'he0) && (c <= 8'hef));
  endfunction

  function automatic logic sj_trail_range(input logic [7:0] c);
    return (c >= 8'h40) && (c <= 8'hfc) && (c != 8'h7f);
  endfunction

  function automatic logic [PenW-1:0] pen_add(input logic [PenW-1:0] a, input int unsigned n);
    int unsigned sum;
    sum = int'(a) + n;
    return (sum > int'(PenMax)) ? PenMax : sum[PenW-1:0];
  endfunction

  function automatic esc_t esc_entry(input int unsigned e);
    esc_t ent;
    case (e)
      0:       ent = '{3'd3, {ChEsc, ChDollar, ChAt, 8'h00, 8'h00, 8'h00}};
      1:       ent = '{3'd3, {ChEsc, ChDollar, ChB, 8'h00, 8'h00, 8'h00}};
      2:       ent = '{3'd6, {ChEsc, ChAmp, ChAt, ChEsc, ChDollar, ChB}};
      3:       ent = '{3'd4, {ChEsc, ChDollar, ChParen, ChD, 8'h00, 8'h00}};
      4:       ent = '{3'd3, {ChEsc, ChParen, ChB, 8'h00, 8'h00, 8'h00}};
      5:       ent = '{3'd3, {ChEsc, ChParen, ChJ, 8'h00, 8'h00, 8'h00}};
      default: ent = '{3'd3, {ChEsc, ChParen, ChI, 8'h00, 8'h00, 8'h00}};
    endcase
    return ent;
  endfunction

  function automatic logic span_has_escape(input logic [0:5][7:0] span);
    esc_t ent;
    logic ok;
    logic hit;
    hit = 1'b0;
    for (int e = 0; e < 7; e++) begin
      ent = esc_entry(e);
      ok  = 1'b1;
      for (int k = 0; k < SpanLen; k++) begin
        if (k < ent.len && span[k] != ent.seq[k]) ok = 1'b0;
      end
      if (ok) hit = 1'b1;
    end
    return hit;
  endfunction

  // EUC-JP score for the byte pair starting at position q
  task automatic score_euc(input int unsigned q, input logic [7:0] lead, input logic [7:0] trail);
    if (euc_pend[8]) begin
      euc_pend = '0;
    end else if (q < int'(scan_lim)) begin
      if (euc_range(lead) || lead == EucKana) begin
        if (q + 1 < int'(scan_lim)) begin
          if ((lead == EucKana) ? kana_range(trail) : euc_range(trail)) begin
            if (lead == EucKana || lead >= EucLevel2) euc_pen = pen_add(euc_pen, 1);
            euc_pend = {1'b1, lead};
          end else begin
            euc_pen = pen_add(euc_pen, 10);
          end
        end
      end else if (lead[7]) begin
        euc_pen = pen_add(euc_pen, 10);
      end
    end
  endtask

  // SJIS score for the byte pair starting at position q
  task automatic score_sjis(input int unsigned q, input logic [7:0] lead, input logic [7:0] trail);
    if (sjis_pend[8]) begin
      sjis_pend = '0;
    end else if (q < int'(scan_lim)) begin
      if (sj_lead_range(lead)) begin
        if (q + 1 < int'(scan_lim)) begin
          if (sj_trail_range(trail)) begin
            if ({lead, trail} >= SjisLevel2) sjis_pen = pen_add(sjis_pen, 1);
            sjis_pend = {1'b1, lead};
          end else begin
            sjis_pen = pen_add(sjis_pen, 10);
          end
        end
      end else if (lead[7]) begin
        sjis_pen = pen_add(sjis_pen, kana_range(lead) ? 1 : 10);
      end
    end
  endtask

  // Advance the scorer by one byte; on the last byte produce the verdict
  task automatic guess_byte(input logic [7:0] c, input logic last,
                            output logic done, output verdict_e v);
    logic [0:5][7:0] span;
    int unsigned     q;
    for (int k = SpanLen - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = c;
    if (byte_pos >= 5 && int'(byte_pos) - 5 < int'(scan_lim)) begin
      for (int k = 0; k < SpanLen; k++) span[k] = win[SpanLen-1-k];
      if (span_has_escape(span)) esc_hit = 1'b1;
    end
    if (byte_pos >= 2) begin
      q = int'(byte_pos) - 2;
      score_euc(q, win[2], win[1]);
      score_sjis(q, win[2], win[1]);
    end
    if (byte_pos != PosMax) byte_pos = byte_pos + 1'b1;
    done = last;
    v    = VerdictAscii;
    if (last) begin
      if (esc_hit)                    v = VerdictIso2022;
      else if (sjis_pen < euc_pen)    v = VerdictSjis;
      else if (sjis_pen > euc_pen)    v = VerdictEuc;
      else if (sjis_pen == '0)        v = VerdictAscii;
      else                            v = VerdictUnknown;
      for (int k = 0; k < SpanLen; k++) win[k] = 8'h00;
      byte_pos  = '0;
      esc_hit   = 1'b0;
      euc_pend  = '0;
      sjis_pend = '0;
      euc_pen   = '0;
      sjis_pen  = '0;
    end
  endtask

  // Score accepted bytes, check verdict transfers, track limit writes
  always @(posedge clk_i) begin
    logic     done;
    verdict_e v;
    verdict_e exp_v;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict: unexpected transfer, got %0d", m_axis_tdata[2:0]);
          fail_cnt++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (m_axis_tdata[2:0] != exp_v) begin
            $error("verdict: expected %0d, got %0d", exp_v, m_axis_tdata[2:0]);
            fail_cnt++;
          end
        end
      end
      if (cfg_wr_en_i) scan_lim = cfg_wr_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        guess_byte(s_axis_tdata, s_axis_tlast, done, v);
        if (done) verdict_q.push_back(pin_on ? pin_want : v);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en_i)
        stall_cnt = 0;
      else
        stall_cnt++;
      if (stall_cnt == StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver: random backpressure, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (hold_start) begin
      hold_start = 1'b0;
      hold_left  = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Offer one byte and hold it until the transfer completes
  task automatic offer_byte(input logic [7:0] b, input logic last);
    logic took;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end
  endtask

  // Drain all verdicts, let the core settle, then write scan_limit
  task automatic program_limit(input logic [15:0] lim);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= lim;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
  endtask

  // Build a random string, mostly of well-formed tokens of one encoding
  task automatic compose_text();
    int unsigned goal;
    int unsigned mode;
    int unsigned kind;
    esc_t        ent;
    int unsigned n;
    logic [7:0]  b;
    text_q.delete();
    goal = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
    mode = $urandom_range(3);
    while (text_q.size() < goal) begin
      kind = ($urandom_range(9) < 6) ? mode : $urandom_range(5);
      case (kind)
        0: begin
          if ($urandom_range(3) == 0) begin
            text_q.push_back(EucKana);
            text_q.push_back(8'($urandom_range(8'ha0, 8'hdf)));
          end else begin
            text_q.push_back(8'($urandom_range(8'ha1, 8'hfe)));
            text_q.push_back(8'($urandom_range(8'ha1, 8'hfe)));
          end
        end
        1: begin
          text_q.push_back($urandom_range(1) ? 8'($urandom_range(8'h81, 8'h9f))
                                             : 8'($urandom_range(8'he0, 8'hef)));
          do b = 8'($urandom_range(8'h40, 8'hfc)); while (b == 8'h7f);
          text_q.push_back(b);
        end
        2: begin
          ent = esc_entry($urandom_range(6));
          n   = ent.len;
          // Break about one escape in four: cut it short or spoil its tail
          if ($urandom_range(3) == 0) begin
            if ($urandom_range(1)) n--;
            else ent.seq[n-1] = 8'($urandom_range(1, 255));
          end
          for (int k = 0; k < n; k++) text_q.push_back(ent.seq[k]);
        end
        3:       text_q.push_back(8'($urandom_range(1, 255)));
        4:       text_q.push_back(8'($urandom_range(1, 127)));
        default: text_q.push_back(8'($urandom_range(8'ha0, 8'hdf)));
      endcase
    end
  endtask

  // Stimulus
  initial begin
    logic [15:0] lim;
    int unsigned sent;
    probe_tab = '{
      '{16'hffff, 4'd1, {8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, VerdictAscii},
      '{16'hffff, 4'd1, {8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, VerdictAscii},
      '{16'hffff, 4'd6, {ChEsc, ChParen, ChJ, 8'h41, 8'h41, 8'h41}, 1'b1, VerdictIso2022},
      '{16'hffff, 4'd5, {ChEsc, ChParen, ChJ, 8'h41, 8'h41, 8'h00}, 1'b1, VerdictAscii},
      '{16'hffff, 4'd3, {8'h98, 8'h9f, 8'h41, 8'h00, 8'h00, 8'h00}, 1'b0, VerdictAscii},
      '{16'hffff, 4'd3, {8'ha1, 8'ha1, 8'h41, 8'h00, 8'h00, 8'h00}, 1'b0, VerdictAscii},
      '{16'hffff, 4'd3, {8'h80, 8'h41, 8'h41, 8'h00, 8'h00, 8'h00}, 1'b1, VerdictUnknown},
      '{16'h0001, 4'd3, {EucKana, 8'ha1, 8'h41, 8'h00, 8'h00, 8'h00}, 1'b1, VerdictAscii},
      '{16'h0000, 4'd3, {8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00}, 1'b1, VerdictAscii}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Probe table: one string per row, the core drained before each
    send_idle = 12;
    recv_idle = 86;
    for (int r = 0; r < NumProbes; r++) begin
      program_limit(probe_tab[r].limit);
      pin_on   = probe_tab[r].pinned;
      pin_want = probe_tab[r].want;
      for (int k = 0; k < probe_tab[r].len; k++)
        offer_byte(probe_tab[r].txt[k], k == probe_tab[r].len - 1);
    end

    // Random strings: three idling regimes, three scan limits each
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin send_idle = 12; recv_idle = 86; end
        1:       begin send_idle = 86; recv_idle = 12; end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
      for (int s = 0; s < 3; s++) begin
        case ((ph + s) % 3)
          0:       lim = LimitReset;
          1:       lim = (ph == 1) ? 16'd1 : 16'($urandom_range(1, 6));
          default: lim = 16'($urandom_range(7, 28));
        endcase
        program_limit(lim);
        pin_on = 1'b0;
        // Stall the output for a long stretch so the input backs up
        if (ph == 2 && s == 0) hold_start = 1'b1;
        sent = 0;
        while (sent < BytesPerSet) begin
          compose_text();
          for (int k = 0; k < text_q.size(); k++)
            offer_byte(text_q[k], k == text_q.size() - 1);
          sent += text_q.size();
        end
      end
    end

    // Drain and finish
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
